// ===== rtl/core/vmph_pkg.sv =====
// Shared types and constants for the peak-hold sound-level meter.
// No dependencies; the front end, curve unit, back end and top level import it.
`timescale 1ns / 1ps

package vmph_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned NUM_PIXELS_DEF       = 256;
  localparam int unsigned CURVE_TABLE_BITS_DEF = 10;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned LEVEL_W    = 9;
  localparam int unsigned DOT_W      = 8;
  localparam int unsigned HANG_W     = 8;
  localparam int unsigned FALL_W     = 4;
  localparam int unsigned HCNT_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Depth of the queue between the front and the back end.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed-point curve arithmetic.
  localparam int unsigned Q16_ONE  = 65536;
  localparam int unsigned P_W      = 17;   // curve value in Q16, up to 1.0
  localparam int unsigned LOG_W    = 21;   // -log2 in Q16, up to 16.0
  localparam int unsigned MANT_W   = 31;   // Q30 mantissa for the squaring loop
  localparam int unsigned SQ_STEPS = 16;
  localparam logic [15:0] CURVE_EXP_Q16 = 16'd41350;

  // Input operation codes.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_END    = 1'b1;

  // Fall counter value after each one-pixel fall.
  localparam logic [FALL_W-1:0] FALL_RELOAD = 4'd2;

  // Configuration register indexes and reset values.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR_LVL   = 2'd0,
    CFG_CEIL_LVL    = 2'd1,
    CFG_HANG_FRAMES = 2'd2,
    CFG_FALL_FRAMES = 2'd3
  } cfg_idx_e;

  localparam logic [SAMPLE_W-1:0] FLOOR_RST   = 10'd10;
  localparam logic [SAMPLE_W-1:0] CEILING_RST = 10'd500;
  localparam logic [HANG_W-1:0]   HANG_RST    = 8'd24;
  localparam logic [FALL_W-1:0]   FALL_RST    = 4'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] floor_lvl;
    logic [SAMPLE_W-1:0] ceil_lvl;
    logic [HANG_W-1:0]   hang_frames;
    logic [FALL_W-1:0]   fall_frames;
  } cfg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_START,
    BK_CURVE,
    BK_SCALE,
    BK_FRAME
  } bk_state_e;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_LOG_SETUP,
    CV_LOG_SQ,
    CV_LOG_END,
    CV_SCALE,
    CV_SRCH_STEP
  } cv_state_e;

endpackage

// ===== rtl/core/vmph_queue.sv =====
// Small FIFO that carries peak-to-peak values from the front to the back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module vmph_queue #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/vmph_front.sv =====
// Front end: accepts input words, tracks the window minimum and maximum,
// and queues the peak-to-peak value at each end of window. Uses vmph_pkg.
`timescale 1ns / 1ps

module vmph_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [vmph_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output logic [vmph_pkg::SAMPLE_W-1:0] q_data_o
);

  import vmph_pkg::*;

  logic [SAMPLE_W-1:0] win_max_q, win_max_d;
  logic [SAMPLE_W-1:0] win_min_q, win_min_d;
  logic                seen_q, seen_d;
  logic                accept;

  // Samples are always taken; an end-of-window word waits for queue space.
  assign in_ready_o = (op_i == OP_SAMPLE) || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && (op_i == OP_END);
  assign q_data_o   = seen_q ? (win_max_q - win_min_q) : '0;

  always_comb begin
    win_max_d = win_max_q;
    win_min_d = win_min_q;
    seen_d    = seen_q;
    if (accept) begin
      if (op_i == OP_END) begin
        win_max_d = '0;
        win_min_d = '1;
        seen_d    = 1'b0;
      end else begin
        if (sample_i > win_max_q) begin
          win_max_d = sample_i;
        end
        if (sample_i < win_min_q) begin
          win_min_d = sample_i;
        end
        seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_max_q <= '0;
      win_min_q <= '1;
      seen_q    <= 1'b0;
    end else begin
      win_max_q <= win_max_d;
      win_min_q <= win_min_d;
      seen_q    <= seen_d;
    end
  end

endmodule

// ===== rtl/core/vmph_curve.sv =====
// Power-curve unit: maps a normalized level n to n^0.631 in Q16 through
// -log2 evaluations on one shared squaring multiplier. Uses vmph_pkg.
`timescale 1ns / 1ps

module vmph_curve #(
  parameter int unsigned CURVE_TABLE_BITS = vmph_pkg::CURVE_TABLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [CURVE_TABLE_BITS:0]   n_i,
  output logic                        done_o,
  output logic [vmph_pkg::P_W-1:0]    p_o
);

  import vmph_pkg::*;

  cv_state_e           state_q, state_d;
  logic [P_W-1:0]      log_v_q, log_v_d;
  logic [MANT_W-1:0]   m_q, m_d;
  logic [4:0]          k_q, k_d;
  logic [15:0]         frac_q, frac_d;
  logic [3:0]          it_q, it_d;
  logic                srch_q, srch_d;
  logic [LOG_W-1:0]    t_q, t_d;
  logic [P_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [P_W-1:0]      p_q, p_d;
  logic                done_q, done_d;

  logic [4:0]          top_idx;
  logic [MANT_W-1:0]   v_ext;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_hi;
  logic [4:0]          fb;
  logic [4:0]          int_part;
  logic [LOG_W-1:0]    log_val;
  logic [LOG_W+15:0]   scaled;
  logic [P_W:0]        mid_sum;

  // Position of the leading one of the operand.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < int'(P_W); i++) begin
      if (log_v_q[i]) begin
        top_idx = 5'(i);
      end
    end
  end

  assign v_ext    = MANT_W'(log_v_q);
  assign sq       = m_q * m_q;
  assign sq_hi    = sq[2*MANT_W-1:MANT_W-1];
  assign fb       = srch_q ? 5'd16 : 5'(CURVE_TABLE_BITS);
  assign int_part = fb - k_q;
  assign log_val  = {int_part, 16'b0} - LOG_W'(frac_q);
  assign scaled   = (LOG_W+16)'(t_q) * (LOG_W+16)'(CURVE_EXP_Q16)
                  + (LOG_W+16)'(Q16_ONE / 2);
  assign mid_sum  = (P_W+1)'(lo_q) + (P_W+1)'(hi_q);

  always_comb begin
    state_d = state_q;
    log_v_d = log_v_q;
    m_d     = m_q;
    k_d     = k_q;
    frac_d  = frac_q;
    it_d    = it_q;
    srch_d  = srch_q;
    t_d     = t_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    p_d     = p_q;
    done_d  = 1'b0;
    unique case (state_q)
      CV_IDLE: begin
        srch_d = 1'b0;
        if (start_i) begin
          if (n_i == '0) begin
            p_d    = '0;
            done_d = 1'b1;
          end else begin
            log_v_d = P_W'(n_i);
            state_d = CV_LOG_SETUP;
          end
        end
      end
      CV_LOG_SETUP: begin
        // Normalize the operand to a Q30 mantissa in [1, 2).
        k_d     = top_idx;
        m_d     = v_ext << (5'(MANT_W - 1) - top_idx);
        frac_d  = '0;
        it_d    = '0;
        state_d = CV_LOG_SQ;
      end
      CV_LOG_SQ: begin
        // Each squaring yields one fraction bit of the logarithm.
        if (sq_hi[MANT_W]) begin
          m_d = sq_hi[MANT_W:1];
        end else begin
          m_d = sq_hi[MANT_W-1:0];
        end
        frac_d = {frac_q[14:0], sq_hi[MANT_W]};
        it_d   = it_q + 1'b1;
        if (it_q == 4'(SQ_STEPS - 1)) begin
          state_d = CV_LOG_END;
        end
      end
      CV_LOG_END: begin
        if (!srch_q) begin
          t_d     = log_val;
          state_d = CV_SCALE;
        end else begin
          if (log_val <= t_q) begin
            hi_d = log_v_q;
          end else begin
            lo_d = log_v_q + 1'b1;
          end
          state_d = CV_SRCH_STEP;
        end
      end
      CV_SCALE: begin
        // Target logarithm times the exponent, rounded.
        t_d     = scaled[LOG_W+15:16];
        lo_d    = P_W'(1);
        hi_d    = P_W'(Q16_ONE);
        srch_d  = 1'b1;
        state_d = CV_SRCH_STEP;
      end
      CV_SRCH_STEP: begin
        // Smallest y whose -log2 does not exceed the target.
        if (lo_q < hi_q) begin
          log_v_d = mid_sum[P_W:1];
          state_d = CV_LOG_SETUP;
        end else begin
          p_d     = lo_q;
          done_d  = 1'b1;
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      srch_q  <= 1'b0;
      it_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      srch_q  <= srch_d;
      it_q    <= it_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    log_v_q <= log_v_d;
    m_q     <= m_d;
    k_q     <= k_d;
    frac_q  <= frac_d;
    t_q     <= t_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    p_q     <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

// ===== rtl/core/vmph_back.sv =====
// Back end: clamps and normalizes each peak-to-peak word, runs the power
// curve, scales to pixels and updates the peak-hold dot. Uses vmph_pkg, vmph_curve.
`timescale 1ns / 1ps

module vmph_back #(
  parameter int unsigned NUM_PIXELS       = vmph_pkg::NUM_PIXELS_DEF,
  parameter int unsigned CURVE_TABLE_BITS = vmph_pkg::CURVE_TABLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vmph_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  logic [vmph_pkg::SAMPLE_W-1:0] q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vmph_pkg::LEVEL_W-1:0]  level_o,
  output logic [vmph_pkg::DOT_W-1:0]    peak_dot_o,
  output logic                          peak_dot_valid_o
);

  import vmph_pkg::*;

  localparam int unsigned DARK_W = $clog2(NUM_PIXELS + 1);
  localparam int unsigned N_W    = CURVE_TABLE_BITS + 1;
  localparam int unsigned DCNT_W = $clog2(N_W);
  localparam int unsigned LIT_W  = P_W + DARK_W;

  bk_state_e           state_q, state_d;
  logic [SAMPLE_W:0]   rem_q, rem_d;
  logic [N_W-1:0]      quo_q, quo_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [P_W-1:0]      p_q, p_d;
  logic [DARK_W-1:0]   dark_q, dark_d;
  logic [DARK_W-1:0]   peak_dark_q, peak_dark_d;
  logic [FALL_W-1:0]   fall_q, fall_d;
  logic [HCNT_W-1:0]   hang_q, hang_d;
  logic                out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [DOT_W-1:0]    dot_q, dot_d;
  logic                dot_valid_q, dot_valid_d;

  logic                cv_start, cv_done;
  logic [P_W-1:0]      cv_p;

  logic [SAMPLE_W-1:0] range;
  logic [SAMPLE_W-1:0] v_clamp;
  logic                div_ge;
  logic [SAMPLE_W:0]   div_diff;
  logic [LIT_W-1:0]    lit_full;
  logic [DARK_W-1:0]   lit;
  logic                new_peak;
  logic [DARK_W-1:0]   pk;
  logic [HCNT_W-1:0]   hc;
  logic                on_strip;
  logic [DARK_W-1:0]   lvl_full;
  logic [DARK_W-1:0]   dot_full;
  logic [FALL_W-1:0]   fc;
  logic                out_free;

  vmph_curve #(
    .CURVE_TABLE_BITS(CURVE_TABLE_BITS)
  ) u_curve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cv_start),
    .n_i    (quo_q),
    .done_o (cv_done),
    .p_o    (cv_p)
  );

  assign range = cfg_i.ceil_lvl - cfg_i.floor_lvl;

  always_comb begin
    if (q_data_i < cfg_i.floor_lvl) begin
      v_clamp = cfg_i.floor_lvl;
    end else if (q_data_i > cfg_i.ceil_lvl) begin
      v_clamp = cfg_i.ceil_lvl;
    end else begin
      v_clamp = q_data_i;
    end
  end

  // One quotient bit a cycle of (v - floor) * 2^bits / range.
  assign div_ge   = (rem_q >= {1'b0, range});
  assign div_diff = rem_q - (div_ge ? {1'b0, range} : '0);

  assign lit_full = LIT_W'(p_q) * LIT_W'(NUM_PIXELS) + LIT_W'(Q16_ONE - 1);
  assign lit      = lit_full[16 +: DARK_W];

  // Peak-hold update for the frame in dark_q.
  assign new_peak = (dark_q < peak_dark_q);
  assign pk       = new_peak ? dark_q : peak_dark_q;
  assign hc       = new_peak ? HCNT_W'(1) : hang_q;
  assign on_strip = (pk < DARK_W'(NUM_PIXELS));
  assign lvl_full = DARK_W'(NUM_PIXELS) - dark_q;
  assign dot_full = DARK_W'(NUM_PIXELS - 1) - pk;
  assign fc       = fall_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    p_d         = p_q;
    dark_d      = dark_q;
    peak_dark_d = peak_dark_q;
    fall_d      = fall_q;
    hang_d      = hang_q;
    out_valid_d = out_valid_q && !out_ready_i;
    level_d     = level_q;
    dot_d       = dot_q;
    dot_valid_d = dot_valid_q;
    q_pop_o     = 1'b0;
    cv_start    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (cfg_i.floor_lvl >= cfg_i.ceil_lvl) begin
            dark_d  = '0;
            state_d = BK_FRAME;
          end else begin
            rem_d   = {1'b0, v_clamp - cfg_i.floor_lvl};
            quo_d   = '0;
            dcnt_d  = '0;
            state_d = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        rem_d  = {div_diff[SAMPLE_W-1:0], 1'b0};
        quo_d  = {quo_q[N_W-2:0], div_ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(N_W - 1)) begin
          state_d = BK_START;
        end
      end
      BK_START: begin
        cv_start = 1'b1;
        state_d  = BK_CURVE;
      end
      BK_CURVE: begin
        if (cv_done) begin
          p_d     = cv_p;
          state_d = BK_SCALE;
        end
      end
      BK_SCALE: begin
        dark_d  = DARK_W'(NUM_PIXELS) - lit;
        state_d = BK_FRAME;
      end
      BK_FRAME: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          level_d     = LEVEL_W'(lvl_full);
          dot_d       = on_strip ? DOT_W'(dot_full) : '0;
          dot_valid_d = on_strip;
          peak_dark_d = pk;
          hang_d      = hc;
          if (hc > HCNT_W'(cfg_i.hang_frames)) begin
            fall_d = fc;
            if (fc >= cfg_i.fall_frames) begin
              fall_d = FALL_RELOAD;
              if (on_strip) begin
                peak_dark_d = pk + 1'b1;
              end
            end
          end else begin
            hang_d = hc + 1'b1;
          end
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      dcnt_q      <= '0;
      peak_dark_q <= DARK_W'(NUM_PIXELS);
      fall_q      <= '0;
      hang_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      peak_dark_q <= peak_dark_d;
      fall_q      <= fall_d;
      hang_q      <= hang_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    p_q         <= p_d;
    dark_q      <= dark_d;
    level_q     <= level_d;
    dot_q       <= dot_d;
    dot_valid_q <= dot_valid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign level_o          = level_q;
  assign peak_dot_o       = dot_q;
  assign peak_dot_valid_o = dot_valid_q;

endmodule

// ===== rtl/core/vu_meter_peak_hold_core.sv =====
// Sound-level bar meter with peak-hold dot: top level with configuration registers.
// Depends on vmph_pkg, vmph_front, vmph_queue and vmph_back.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i/in_ready_o) takes words of op_i and sample_i.
// A sample word (op 0) updates the window minimum and maximum in the cycle it
// is accepted and produces no result. An end-of-window word (op 1) queues the
// peak-to-peak value and yields exactly one result word on the output channel
// (out_valid_o/out_ready_i): level_o, peak_dot_o and peak_dot_valid_o.
// Samples are taken every cycle; an end-of-window word is held off only while
// the two-entry queue to the back end is full.
// The back end handles one window at a time. A window that leaves the queue
// goes through the division, 17 logarithm evaluations on the single squaring
// multiplier of the curve unit, and setup, scaling and frame update before it
// shows up as a valid result. A zero normalized level skips the logarithm
// evaluations; a floor not below the ceiling skips the division too.
// A finished word waits in the output register while the receiver stalls;
// the back end then holds its next window and the queue fills behind it.
// Reset restores the register defaults (floor 10, ceiling 500, hang 24,
// fall 4), empties the window and the queue, and parks the dot off the strip.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle, which the block itself does not enforce.

module vu_meter_peak_hold_core #(
  parameter int unsigned NUM_PIXELS       = vmph_pkg::NUM_PIXELS_DEF,
  parameter int unsigned CURVE_TABLE_BITS = vmph_pkg::CURVE_TABLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vmph_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vmph_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [vmph_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vmph_pkg::LEVEL_W-1:0]    level_o,
  output logic [vmph_pkg::DOT_W-1:0]      peak_dot_o,
  output logic                            peak_dot_valid_o
);

  import vmph_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic                q_push, q_full, q_pop, q_empty;
  logic [SAMPLE_W-1:0] q_wdata, q_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FLOOR_LVL:   cfg_d.floor_lvl   = cfg_data_i[SAMPLE_W-1:0];
        CFG_CEIL_LVL:    cfg_d.ceil_lvl    = cfg_data_i[SAMPLE_W-1:0];
        CFG_HANG_FRAMES: cfg_d.hang_frames = cfg_data_i[HANG_W-1:0];
        CFG_FALL_FRAMES: cfg_d.fall_frames = cfg_data_i[FALL_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.floor_lvl   <= FLOOR_RST;
      cfg_q.ceil_lvl    <= CEILING_RST;
      cfg_q.hang_frames <= HANG_RST;
      cfg_q.fall_frames <= FALL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vmph_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .sample_i  (sample_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  vmph_queue #(
    .WIDTH(SAMPLE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  vmph_back #(
    .NUM_PIXELS      (NUM_PIXELS),
    .CURVE_TABLE_BITS(CURVE_TABLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .level_o         (level_o),
    .peak_dot_o      (peak_dot_o),
    .peak_dot_valid_o(peak_dot_valid_o)
  );

endmodule
